/* hdl/dtm_pkg.sv */
// Shared types and constants for the divergence threshold monitor.
// No dependencies.
`default_nettype none
package dtm_pkg;
    typedef struct packed {
        logic [31:0]        time_ms;
        logic               has_divergence;
        logic signed [23:0] divergence_um;
        logic [23:0]        reported_sigma_um;
        logic               learnable;
    } dtm_in_t;

    typedef struct packed {
        logic [31:0]        threshold_um;
        logic               empirical;
        logic               divergence_valid;
        logic signed [23:0] divergence_echo_um;
        logic               onset_valid;
        logic [31:0]        onset_ms;
    } dtm_out_t;

    localparam logic [2:0] REG_GAIN   = 3'd0;
    localparam logic [2:0] REG_WINDOW = 3'd1;
    localparam logic [2:0] REG_FLOOR  = 3'd2;
    localparam logic [2:0] REG_CAP    = 3'd3;
    localparam logic [2:0] REG_MINS   = 3'd4;

    typedef struct packed {
        logic load;
        logic prune_step;
        logic gap;
        logic sum_start;
        logic sum_step;
        logic div_start;
        logic sqrt_start;
        logic finish;
    } dtm_cmd_t;

    typedef struct packed {
        logic prune_more;
        logic use_window;
        logic sum_done;
        logic div_done;
        logic sqrt_done;
    } dtm_status_t;
endpackage
`default_nettype wire

/* hdl/dtm_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module dtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/dtm_ctrl.sv */
// Sequencer of the divergence threshold monitor.
// Depends on dtm_pkg.
`default_nettype none
module dtm_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire                  m_ready,
    input  wire dtm_pkg::dtm_status_t sts,
    output dtm_pkg::dtm_cmd_t    cmd
);
    import dtm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRUNE = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;
    logic       prune_wait_reg, prune_wait_next;

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        mv_next = mv_reg && !m_ready;
        prune_wait_next = 1'b0;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    prune_wait_next = 1'b1;
                    state_next = ST_PRUNE;
                end
            end
            ST_PRUNE: begin
                // The prune wait flag set after each head move lets the RAM read settle.
                if (!prune_wait_reg) begin
                    if (sts.prune_more) begin
                        cmd.prune_step = 1'b1;
                        prune_wait_next = 1'b1;
                    end else begin
                        cmd.gap = 1'b1;
                        if (sts.use_window) begin
                            cmd.sum_start = 1'b1;
                            state_next = ST_SUM;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_SUM: begin
                if (sts.sum_done) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    cmd.sum_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sts.sqrt_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                mv_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg <= 1'b0;
            prune_wait_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
            prune_wait_reg <= prune_wait_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/dtm_datapath.sv */
// Datapath: window memories, sum of squares, divider, square root, threshold.
// Depends on dtm_pkg and dtm_ram.
`default_nettype none
module dtm_datapath #(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_we,
    input  wire [2:0]             cfg_index,
    input  wire [31:0]            cfg_data,
    input  wire dtm_pkg::dtm_in_t s_data,
    output dtm_pkg::dtm_out_t     m_data,
    input  wire dtm_pkg::dtm_cmd_t cmd,
    output dtm_pkg::dtm_status_t  sts
);
    import dtm_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_C = AW'(WINDOW_DEPTH - 1);

    logic [15:0] gain_reg;
    logic [31:0] win_ms_reg;
    logic [23:0] floor_reg, cap_reg;
    logic [6:0]  mins_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= 16'd768;
            win_ms_reg <= 32'd30000;
            floor_reg <= 24'd50000;
            cap_reg <= 24'd1000000;
            mins_reg <= 7'd10;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GAIN:   gain_reg <= cfg_data[15:0];
                REG_WINDOW: win_ms_reg <= cfg_data;
                REG_FLOOR:  floor_reg <= cfg_data[23:0];
                REG_CAP:    cap_reg <= cfg_data[23:0];
                REG_MINS:   mins_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    dtm_in_t in_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic warm_reg, hval_reg, onact_reg, lpv_reg;
    logic [23:0] held_reg;
    logic [31:0] ontime_reg, lpt_reg;
    logic gap_reg, usew_reg;

    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] raddr;
    logic [31:0] rd_time;
    logic [23:0] rd_val;
    logic we;
    logic [AW-1:0] waddr;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
        return (a == LAST_C) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, a} + {1'b0, b};
        if (s >= (CW+1)'(WINDOW_DEPTH)) begin
            s = s - (CW+1)'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign raddr = cmd.prune_step ? inc(head_reg) :
                   (cmd.load ? head_reg : (cmd.sum_start ? head_reg : rd_idx_reg));

    dtm_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_time (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(in_reg.time_ms),
        .raddr(raddr), .rdata(rd_time));
    dtm_ram #(.WIDTH(24), .DEPTH(WINDOW_DEPTH)) u_val (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(in_reg.divergence_um),
        .raddr(raddr), .rdata(rd_val));

    // Prune test and gap test, both without wrap.
    logic [32:0] limit;
    logic        limit_neg;
    logic signed [33:0] gap_diff;
    assign limit = {1'b0, in_reg.time_ms} - {1'b0, win_ms_reg};
    assign limit_neg = limit[32];
    assign sts.prune_more = (count_reg != '0) && !limit_neg && (rd_time <= limit[31:0]);
    assign gap_diff = $signed({2'b0, in_reg.time_ms}) - $signed({2'b0, lpt_reg});
    wire gap_hit = lpv_reg && (gap_diff >= $signed({2'b0, win_ms_reg}));
    assign sts.use_window = (count_reg != '0) && (32'(count_reg) >= 32'(mins_reg));

    // Sum of squares, one entry per cycle, behind the registered RAM read.
    logic [CW-1:0] sum_cnt_reg;
    logic          sum_lead_reg;
    logic [63:0]   sum_reg;
    logic [23:0]   absv;
    assign absv = rd_val[23] ? 24'(-$signed(rd_val)) : rd_val;
    assign sts.sum_done = (sum_cnt_reg == count_reg) && !sum_lead_reg;

    // Restoring divider, one bit per cycle.
    logic [63:0] quo_reg;
    logic [CW:0] rem_reg;
    logic [6:0]  div_cnt_reg;
    logic        div_busy_reg;
    logic [CW:0] rem_sh;
    assign rem_sh = {rem_reg[CW-1:0], quo_reg[63]};
    assign sts.div_done = !div_busy_reg && (div_cnt_reg == 7'd64);

    // Square root, two bits per cycle.
    logic [63:0] sq_v_reg, sq_res_reg, sq_bit_reg;
    logic        sq_busy_reg;
    assign sts.sqrt_done = !sq_busy_reg && (sq_bit_reg == '0);

    logic [31:0] rms_c;
    logic [31:0] base_c, sigma_c;
    logic [39:0] prod;
    logic [31:0] thr_c;
    logic        emp_c;
    logic        warm_g, hval_g, onact_g;
    logic [31:0] ontime_g;
    logic [23:0] held_g;
    logic        warm_a;
    logic        exceed;

    always_comb begin
        rms_c = sq_res_reg[31:0];
        if (rms_c < 32'(floor_reg)) rms_c = 32'(floor_reg);
        if (rms_c > 32'(cap_reg)) rms_c = 32'(cap_reg);
        warm_g = warm_reg;
        hval_g = hval_reg;
        held_g = held_reg;
        onact_g = onact_reg;
        ontime_g = ontime_reg;
        if (gap_reg) begin
            warm_g = 1'b1;
            hval_g = 1'b0;
            held_g = '0;
            onact_g = 1'b0;
            ontime_g = '0;
        end
        base_c = '0;
        emp_c = 1'b0;
        if (usew_reg) begin
            base_c = rms_c;
            emp_c = 1'b1;
        end else if (!warm_g && hval_g) begin
            base_c = 32'(held_g);
            emp_c = 1'b1;
        end
        sigma_c = 32'(floor_reg);
        if (base_c > sigma_c) sigma_c = base_c;
        if (32'(in_reg.reported_sigma_um) > sigma_c) sigma_c = 32'(in_reg.reported_sigma_um);
        prod = 40'(gain_reg) * 40'(sigma_c[23:0]);
        thr_c = (prod[39:8] > 32'hFFFFFFFF) ? 32'hFFFFFFFF : prod[39:8];
        warm_a = warm_g;
        if (warm_g && (32'(count_reg) >= 32'(mins_reg))) warm_a = 1'b0;
        exceed = $signed({{10{in_reg.divergence_um[23]}}, in_reg.divergence_um}) >
                 $signed({2'b0, thr_c});
    end

    assign we = cmd.finish && in_reg.has_divergence && in_reg.learnable &&
                (!exceed || warm_a);
    assign waddr = (count_reg == DEPTH_C) ? head_reg : wrap_add(head_reg, count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            sq_busy_reg <= 1'b0;
            div_cnt_reg <= '0;
            sq_bit_reg <= '0;
            sum_lead_reg <= 1'b0;
            sum_cnt_reg <= '0;
            gap_reg <= 1'b0;
            usew_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                in_reg <= s_data;
            end
            if (cmd.sum_start) begin
                rd_idx_reg <= inc(head_reg);
            end else if (cmd.sum_step) begin
                rd_idx_reg <= inc(rd_idx_reg);
            end else begin
                rd_idx_reg <= raddr;
            end
            if (cmd.gap) begin
                gap_reg <= gap_hit;
                usew_reg <= sts.use_window;
            end
            if (cmd.sum_start) begin
                sum_reg <= '0;
                sum_cnt_reg <= '0;
                sum_lead_reg <= 1'b1;
            end else if (cmd.sum_step) begin
                sum_lead_reg <= 1'b0;
                sum_reg <= sum_reg + 64'(absv) * 64'(absv);
                sum_cnt_reg <= sum_cnt_reg + 1'b1;
            end
            if (cmd.div_start) begin
                quo_reg <= sum_reg;
                rem_reg <= '0;
                div_cnt_reg <= '0;
                div_busy_reg <= 1'b1;
            end else if (div_busy_reg) begin
                if (rem_sh >= {1'b0, count_reg}) begin
                    rem_reg <= rem_sh - {1'b0, count_reg};
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == 7'd63) div_busy_reg <= 1'b0;
            end
            if (cmd.sqrt_start) begin
                sq_v_reg <= quo_reg;
                sq_res_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
                sq_busy_reg <= 1'b1;
            end else if (sq_busy_reg) begin
                if (sq_v_reg >= sq_res_reg + sq_bit_reg) begin
                    sq_v_reg <= sq_v_reg - (sq_res_reg + sq_bit_reg);
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                if (sq_bit_reg[1:0] != 2'b00 || sq_bit_reg == 64'd1) sq_busy_reg <= 1'b0;
            end
        end
    end

    logic onact_n;
    logic [31:0] ontime_n;
    always_comb begin
        onact_n = 1'b0;
        ontime_n = '0;
        if (in_reg.has_divergence) begin
            onact_n = onact_g;
            ontime_n = ontime_g;
            if (warm_g && !warm_a) begin
                onact_n = 1'b0;
                ontime_n = '0;
            end
            if (exceed) begin
                if (!onact_n) begin
                    onact_n = 1'b1;
                    ontime_n = in_reg.time_ms;
                end
            end else begin
                onact_n = 1'b0;
                ontime_n = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            count_reg <= '0;
            warm_reg <= 1'b1;
            hval_reg <= 1'b0;
            held_reg <= '0;
            onact_reg <= 1'b0;
            ontime_reg <= '0;
            lpv_reg <= 1'b0;
            lpt_reg <= '0;
            m_data <= '0;
        end else begin
            if (cmd.prune_step) begin
                head_reg <= inc(head_reg);
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.finish) begin
                hval_reg <= usew_reg ? 1'b1 : hval_g;
                held_reg <= usew_reg ? rms_c[23:0] : held_g;
                onact_reg <= onact_n;
                ontime_reg <= ontime_n;
                m_data.threshold_um <= thr_c;
                m_data.empirical <= emp_c;
                m_data.divergence_valid <= in_reg.has_divergence;
                m_data.divergence_echo_um <= in_reg.has_divergence ? in_reg.divergence_um : '0;
                m_data.onset_valid <= onact_n;
                m_data.onset_ms <= onact_n ? ontime_n : '0;
                if (in_reg.has_divergence) begin
                    warm_reg <= warm_a;
                    lpv_reg <= 1'b1;
                    lpt_reg <= in_reg.time_ms;
                end else begin
                    warm_reg <= warm_g;
                end
                if (we) begin
                    if (count_reg == DEPTH_C) begin
                        head_reg <= inc(head_reg);
                    end else begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/divergence_threshold_monitor.sv */
// Top level of the divergence threshold monitor.
// Depends on dtm_pkg, dtm_ctrl and dtm_datapath.
//
//  Channel | Ports                          | Carries
//  input   | s_valid, s_ready, s_data       | one sample word
//  output  | m_valid, m_ready, m_data       | one result word
//  config  | cfg_we, cfg_index, cfg_data    | register writes
//
// After acceptance the block prunes expired entries, each with a read wait; when the
// window supplies the baseline it then sums the squares of the window fill and runs
// the 64-step divider and the 32-step square root before the result is written.
// Reset is synchronous and active low. A new word is taken from the cycle after
// the previous result has been taken by the output side.
`default_nettype none
module divergence_threshold_monitor #(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_we,
    input  wire [2:0]             cfg_index,
    input  wire [31:0]            cfg_data,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire dtm_pkg::dtm_in_t s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output dtm_pkg::dtm_out_t     m_data
);
    import dtm_pkg::*;

    dtm_cmd_t    cmd;
    dtm_status_t sts;

    dtm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd));

    dtm_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_data(s_data), .m_data(m_data), .cmd(cmd), .sts(sts));
endmodule
`default_nettype wire

/* dv/divergence_threshold_monitor_tb.sv */
// Testbench for the divergence threshold monitor: drives sample words, models the
// window, baseline, threshold and onset logic, and checks every result word.
// Depends on dtm_pkg and divergence_threshold_monitor.
module divergence_threshold_monitor_tb;
    import dtm_pkg::*;

    localparam int DEPTH = 64;
    localparam int HOLD_LEN = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_GAIN;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    dtm_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    dtm_out_t    m_data;

    divergence_threshold_monitor #(.WINDOW_DEPTH(DEPTH)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Shadow configuration and state.
    logic [15:0] gain_q8;
    logic [31:0] win_ms;
    logic [23:0] floor_um, cap_um;
    logic [6:0]  min_cnt;
    logic [31:0] wtime [DEPTH];
    logic signed [23:0] wval [DEPTH];
    int unsigned whead, wcount;
    bit warming, held_valid, onset_on, last_valid;
    logic [31:0] held_um, onset_t, last_t;

    dtm_out_t expected_words[$];
    int mismatches = 0;
    int words_checked = 0;
    int onsets_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    bit hold_req = 1'b0;
    logic [31:0] now_ms = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            logic [63:0] c;
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    task automatic reset_shadow();
        gain_q8 = 16'd768; win_ms = 32'd30000; floor_um = 24'd50000;
        cap_um = 24'd1000000; min_cnt = 7'd10;
        whead = 0; wcount = 0; warming = 1; held_valid = 0; held_um = 0;
        onset_on = 0; onset_t = 0; last_valid = 0; last_t = 0;
    endtask

    function automatic void push_entry(logic [31:0] t, logic signed [23:0] d);
        int unsigned slot;
        if (wcount >= DEPTH) begin
            whead = (whead + 1) % DEPTH;
            wcount = DEPTH - 1;
        end
        slot = (whead + wcount) % DEPTH;
        wtime[slot] = t; wval[slot] = d;
        wcount++;
    endfunction

    function automatic dtm_out_t predict_result(dtm_in_t w);
        dtm_out_t r;
        longint lim;
        logic [31:0] base, sig;
        logic [63:0] thr, sum, rms;
        bit emp;
        r = '0; base = 0; emp = 0; sum = 0;
        lim = longint'(w.time_ms) - longint'(win_ms);
        while (wcount > 0 && longint'(wtime[whead]) <= lim) begin
            whead = (whead + 1) % DEPTH;
            wcount--;
        end
        if (last_valid && longint'(w.time_ms) - longint'(last_t) >= longint'(win_ms)) begin
            warming = 1; held_valid = 0; held_um = 0; onset_on = 0; onset_t = 0;
        end
        if (wcount > 0 && wcount >= min_cnt) begin
            for (int i = 0; i < wcount; i++) begin
                longint a;
                a = wval[(whead + i) % DEPTH];
                if (a < 0) a = -a;
                sum += a * a;
            end
            rms = int_sqrt(sum / wcount);
            if (rms < floor_um) rms = floor_um;
            if (rms > cap_um) rms = cap_um;
            base = rms[31:0]; held_um = base; held_valid = 1; emp = 1;
        end else if (!warming && held_valid) begin
            base = held_um; emp = 1;
        end
        sig = floor_um;
        if (base > sig) sig = base;
        if (w.reported_sigma_um > sig) sig = w.reported_sigma_um;
        thr = (64'(gain_q8) * sig) >> 8;
        if (thr > 64'hFFFF_FFFF) thr = 64'hFFFF_FFFF;
        r.threshold_um = thr[31:0];
        r.empirical = emp;
        if (!w.has_divergence) begin
            onset_on = 0; onset_t = 0;
            return r;
        end
        last_valid = 1; last_t = w.time_ms;
        if (warming && wcount >= min_cnt) begin
            warming = 0; onset_on = 0; onset_t = 0;
        end
        if (longint'(w.divergence_um) > longint'(thr)) begin
            if (!onset_on) begin
                onset_on = 1; onset_t = w.time_ms;
            end
            if (warming && w.learnable) push_entry(w.time_ms, w.divergence_um);
        end else begin
            onset_on = 0; onset_t = 0;
            if (w.learnable) push_entry(w.time_ms, w.divergence_um);
        end
        r.divergence_valid = 1;
        r.divergence_echo_um = w.divergence_um;
        r.onset_valid = onset_on;
        r.onset_ms = onset_on ? onset_t : 32'd0;
        return r;
    endfunction

    task automatic send_word(dtm_in_t w);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= w;
        expected_words.push_back(predict_result(w));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GAIN:   gain_q8 = val[15:0];
            REG_WINDOW: win_ms = val;
            REG_FLOOR:  floor_um = val[23:0];
            REG_CAP:    cap_um = val[23:0];
            REG_MINS:   min_cnt = val[6:0];
            default: ;
        endcase
    endtask

    function automatic dtm_in_t make_sample(logic [31:0] t, bit paired,
                                            logic signed [23:0] d, logic [23:0] rep,
                                            bit learn);
        dtm_in_t w;
        w.time_ms = t; w.has_divergence = paired; w.divergence_um = d;
        w.reported_sigma_um = rep; w.learnable = learn;
        return w;
    endfunction

    // Mostly paired learnable samples about a second apart, with rare big jumps.
    task automatic send_random(int n, int spread);
        for (int i = 0; i < n; i++) begin
            int k;
            logic [31:0] step;
            logic signed [23:0] d;
            k = $urandom_range(99);
            step = (k < 3) ? $urandom : (k < 6) ? 32'd0 : $urandom_range(2000);
            if (now_ms > 32'hFFFF_0000 && k > 10) now_ms = $urandom_range(1000);
            now_ms = now_ms + step;
            if ($urandom_range(19) == 0) d = 24'($urandom);
            else d = 24'(int'($urandom_range(2 * spread)) - spread);
            send_word(make_sample(now_ms, $urandom_range(9) != 0, d,
                                  ($urandom_range(9) == 0) ? 24'($urandom) :
                                  24'($urandom_range(spread)),
                                  $urandom_range(7) != 0));
        end
    endtask

    always @(negedge aclk) begin
        if (hold_req) begin
            m_ready <= 1'b0;
            hold_cycles <= HOLD_LEN;
        end else if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_data);
            end else begin
                dtm_out_t e;
                e = expected_words[0];
                expected_words.delete(0);
                words_checked++;
                if (m_data.onset_valid) onsets_seen++;
                if (m_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: thr %0d/%0d emp %0b/%0b dv %0b/%0b echo %0d/%0d",
                                 e.threshold_um, m_data.threshold_um, e.empirical,
                                 m_data.empirical, e.divergence_valid,
                                 m_data.divergence_valid, e.divergence_echo_um,
                                 m_data.divergence_echo_um);
                        $display("          onset %0b/%0b at %0d/%0d", e.onset_valid,
                                 m_data.onset_valid, e.onset_ms, m_data.onset_ms);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        dtm_in_t w;
        for (int i = 0; i < 12; i++)
            send_word(make_sample(1000 * i, 1, 24'(1000 * i - 5000), 0, 1));
        send_word(make_sample(12000, 1, 24'sh7FFFFF, 24'hFFFFFF, 1));
        send_word(make_sample(12500, 1, 24'sh7FFFFF, 0, 1));
        send_word(make_sample(13000, 1, 24'sh800000, 0, 1));
        send_word(make_sample(13500, 0, 24'sh123456, 24'h00FFFF, 1));
        send_word(make_sample(13000, 1, 24'sd10, 0, 0));
        send_word(make_sample(80000, 1, 24'sd10, 0, 1));
        send_word(make_sample(32'hFFFF_FFFF, 1, -24'sd1, 0, 1));
        w = make_sample(32'hFFFF_FFFF, 1, 24'sh7FFFFF, 24'h000001, 0);
        send_word(w);
        now_ms = 0;
    endtask

    task automatic test_config_extremes();
        write_reg(REG_GAIN, 32'hFFFF);
        write_reg(REG_FLOOR, 32'hFFFFFF);
        write_reg(REG_CAP, 32'd0);
        write_reg(REG_MINS, 32'd0);
        write_reg(REG_WINDOW, 32'd0);
        send_word(make_sample(5, 1, 24'sd3, 0, 1));
        send_word(make_sample(5, 1, 24'sd3, 0, 1));
        write_reg(REG_WINDOW, 32'hFFFF_FFFF);
        write_reg(REG_MINS, 32'd64);
        write_reg(REG_CAP, 32'hFFFFFF);
        write_reg(REG_FLOOR, 32'd0);
        write_reg(REG_GAIN, 32'd0);
        send_random(60, 4000);
        write_reg(REG_MINS, 32'd65);
        send_random(80, 4000);
    endtask

    task automatic test_random_phases();
        write_reg(REG_GAIN, 32'd512);
        write_reg(REG_WINDOW, 32'd20000);
        write_reg(REG_FLOOR, 32'd1000);
        write_reg(REG_CAP, 32'd50000);
        write_reg(REG_MINS, 32'd4);
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(350, 8000);
        send_idle_pct = 85; recv_stall_pct = 0;  send_random(300, 8000);
        write_reg(REG_MINS, 32'd1);
        write_reg(REG_GAIN, 32'd300);
        send_idle_pct = 0;  recv_stall_pct = 85; send_random(300, 20000);
        write_reg(REG_WINDOW, 32'd5000);
        send_idle_pct = 28; recv_stall_pct = 28; send_random(300, 20000);
        write_reg(REG_MINS, 32'd10);
        write_reg(REG_WINDOW, 32'd30000);
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(200, 60000);
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        @(negedge aclk);
        hold_req <= 1'b0;
        send_idle_pct = 0;
        send_random(140, 8000);
    endtask

    initial begin
        reset_shadow();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_config_extremes();
        test_random_phases();
        test_backpressure();
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        $display("Checked %0d result words over directed edges, register extremes,",
                 words_checked);
        $display("idle and stall phases and a long output hold; %0d onsets seen.",
                 onsets_seen);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
